// ----- rtl/core/bala_pkg.sv -----
// ----------------------------------------------------------------------------
// bala_pkg: shared constants for the Bezier arc length quadrature engine
// Node tables, fixed internal widths and register indexes.
// ----------------------------------------------------------------------------
package bala_pkg;

	localparam int NODES   = 10;
	localparam int B_W     = 17;
	localparam int REG_W   = 48;
	localparam int U_W     = 31;
	localparam int T_W     = 31;
	localparam int WT_W    = 30;
	localparam int M_W     = 29;
	localparam int SQ_W    = 58;
	localparam int NORM_W  = 29;
	localparam int PROD_W  = 59;
	localparam int LEN_W   = 27;

	localparam int DERIV_LAT = 8;
	localparam int LANE_LAT  = DERIV_LAT + NORM_W + 1;

	localparam logic [1:0] REG_POINT_0 = 2'd0;
	localparam logic [1:0] REG_POINT_1 = 2'd1;
	localparam logic [1:0] REG_POINT_2 = 2'd2;
	localparam logic [1:0] REG_POINT_3 = 2'd3;

	// Node positions as 1 + offset in Q1.30; unused lanes of the three-node
	// rule sit at the midpoint with zero weight.
	localparam logic [U_W-1:0] U3 [NODES] = '{
		31'd1073741824, 31'd242024984, 31'd1905458664,
		31'd1073741824, 31'd1073741824, 31'd1073741824, 31'd1073741824,
		31'd1073741824, 31'd1073741824, 31'd1073741824
	};
	localparam logic [WT_W-1:0] W3 [NODES] = '{
		30'd954437177, 30'd596523236, 30'd596523236,
		30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0
	};
	localparam logic [U_W-1:0] U10 [NODES] = '{
		31'd913889220, 31'd1233594428, 31'd608387063, 31'd1539096585,
		31'd344231355, 31'd1803252293, 31'd144887107, 31'd2002596541,
		31'd28017652, 31'd2119465996
	};
	localparam logic [WT_W-1:0] W10 [NODES] = '{
		30'd317316720, 30'd317316720, 30'd289122938, 30'd289122938,
		30'd235242191, 30'd235242191, 30'd160472164, 30'd160472164,
		30'd71587811, 30'd71587811
	};

endpackage

// ----- rtl/core/bala_deriv.sv -----
// ----------------------------------------------------------------------------
// bala_deriv: derivative magnitude squared at one quadrature node
// Eight stages: node parameter, Bernstein products, coefficients, partial
// products, component sums, rounding, squares and the sum of squares.
// ----------------------------------------------------------------------------
module bala_deriv #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [bala_pkg::B_W-1:0]           b,
	input  logic                               mode,
	input  logic [bala_pkg::U_W-1:0]           u,
	input  logic signed [COORD_WIDTH:0]        diff [3][3],
	output logic [bala_pkg::SQ_W-1:0]          sumsq,
	output logic                               mode_o
);
	import bala_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int CW = 48 - W;
	localparam int SH = 14 + W;
	localparam int PW = CW + W + 2;
	localparam int DW = PW + 2;

	logic [47:0]          bu;
	logic [T_W-1:0]       t_n, s_n;
	logic [T_W-1:0]       t_s1;
	logic [61:0]          ss_s2, ts_s2, tt_s2;
	logic [61:0]          rss, rts, rtt;
	logic [CW-1:0]        c_s3 [3];
	logic signed [PW-1:0] p_s4 [3][3];
	logic signed [PW-1:0] p_n [3][3];
	logic signed [DW-1:0] d_s5 [3];
	logic [DW-1:0]        mag [3];
	logic [M_W-1:0]       m_s6 [3];
	logic [SQ_W-1:0]      sq_s7 [3];
	logic [SQ_W-1:0]      sumsq_s8;
	logic                 mode_s [DERIV_LAT];

	assign bu  = 48'(b) * 48'(u);
	assign t_n = T_W'((bu + 48'd65536) >> 17);
	assign s_n = T_W'(31'd1073741824 - t_s1);
	assign rss = (ss_s2 + (62'd1 << (SH - 1))) >> SH;
	assign rts = (ts_s2 + (62'd1 << (SH - 1))) >> SH;
	assign rtt = (tt_s2 + (62'd1 << (SH - 1))) >> SH;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				p_n[k][j] = PW'($signed({1'b0, c_s3[j]})) * PW'(diff[k][j]);
			end
			mag[k] = d_s5[k][DW-1] ? DW'(-d_s5[k]) : DW'(d_s5[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= t_n;
			ss_s2 <= 62'(s_n) * 62'(s_n);
			ts_s2 <= 62'(t_s1) * 62'(s_n);
			tt_s2 <= 62'(t_s1) * 62'(t_s1);
			c_s3[0] <= CW'((rss << 1) + rss);
			c_s3[1] <= CW'((rts << 2) + (rts << 1));
			c_s3[2] <= CW'((rtt << 1) + rtt);
			p_s4 <= p_n;
			for (int k = 0; k < 3; k++) begin
				d_s5[k]  <= DW'(p_s4[k][0]) + DW'(p_s4[k][1]) + DW'(p_s4[k][2]);
				m_s6[k]  <= M_W'((mag[k] + (DW'(1) << 19)) >> 20);
				sq_s7[k] <= SQ_W'(m_s6[k]) * SQ_W'(m_s6[k]);
			end
			sumsq_s8 <= sq_s7[0] + sq_s7[1] + sq_s7[2];
			mode_s[0] <= mode;
			for (int i = 1; i < DERIV_LAT; i++) begin
				mode_s[i] <= mode_s[i-1];
			end
		end
	end

	assign sumsq  = sumsq_s8;
	assign mode_o = mode_s[DERIV_LAT-1];

endmodule

// ----- rtl/core/bala_isqrt.sv -----
// ----------------------------------------------------------------------------
// bala_isqrt: pipelined floor square root
// One result bit per stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module bala_isqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [bala_pkg::SQ_W-1:0]     rad,
	input  logic                          mode,
	output logic [bala_pkg::NORM_W-1:0]   root,
	output logic                          mode_o
);
	import bala_pkg::*;

	localparam int N  = NORM_W;
	localparam int RW = NORM_W + 2;

	logic [RW-1:0]     rem_s  [N];
	logic [NORM_W-1:0] root_s [N];
	logic [SQ_W-1:0]   rad_s  [N];
	logic              mode_s [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [RW-1:0]     rem_in, rem_sh, trial;
		logic [NORM_W-1:0] root_in;
		logic [SQ_W-1:0]   rad_in;
		logic              mode_in, ge;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
			assign mode_in = mode;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign rad_in  = rad_s[i-1];
			assign mode_in = mode_s[i-1];
		end

		assign rem_sh = {rem_in[RW-3:0], rad_in[SQ_W-1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? rem_sh - trial : rem_sh;
				root_s[i] <= {root_in[NORM_W-2:0], ge};
				rad_s[i]  <= rad_in << 2;
				mode_s[i] <= mode_in;
			end
		end
	end

	assign root   = root_s[N-1];
	assign mode_o = mode_s[N-1];

endmodule

// ----- rtl/core/bala_lane.sv -----
// ----------------------------------------------------------------------------
// bala_lane: one quadrature node lane
// Derivative norm at the node, times the node weight of the selected rule.
// ----------------------------------------------------------------------------
module bala_lane #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [bala_pkg::B_W-1:0]           b,
	input  logic                               mode,
	input  logic [bala_pkg::U_W-1:0]           u,
	input  logic [bala_pkg::WT_W-1:0]          w3,
	input  logic [bala_pkg::WT_W-1:0]          w10,
	input  logic signed [COORD_WIDTH:0]        diff [3][3],
	output logic [bala_pkg::PROD_W-1:0]        prod
);
	import bala_pkg::*;

	logic [SQ_W-1:0]   sumsq;
	logic [NORM_W-1:0] norm;
	logic              mode_d, mode_r;
	logic [PROD_W-1:0] prod_s1;

	bala_deriv #(.COORD_WIDTH(COORD_WIDTH)) u_deriv (
		.clk   (clk),
		.en    (en),
		.b     (b),
		.mode  (mode),
		.u     (u),
		.diff  (diff),
		.sumsq (sumsq),
		.mode_o(mode_d)
	);

	bala_isqrt u_isqrt (
		.clk   (clk),
		.en    (en),
		.rad   (sumsq),
		.mode  (mode_d),
		.root  (norm),
		.mode_o(mode_r)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(mode_r ? w10 : w3) * PROD_W'(norm);
		end
	end

	assign prod = prod_s1;

endmodule

// ----- rtl/core/bala_sum.sv -----
// ----------------------------------------------------------------------------
// bala_sum: weighted sum, scaling, saturation and output buffer
// Adder tree over the lanes, scale by half the limit, clamp, two-entry skid.
// ----------------------------------------------------------------------------
module bala_sum #(
	parameter int COORD_WIDTH      = 16,
	parameter int LENGTH_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vld,
	input  logic [bala_pkg::B_W-1:0]          b,
	input  logic [bala_pkg::PROD_W-1:0]       prod [bala_pkg::NODES],
	input  logic                              out_stall,
	output logic                              en,
	output logic                              out_valid,
	output logic [bala_pkg::LEN_W-1:0]        arc_length,
	output logic                              saturated
);
	import bala_pkg::*;

	localparam int NORM_FRAC = 26 - COORD_WIDTH + COORD_WIDTH / 2;
	localparam int FS        = NORM_FRAC + 17 - LENGTH_FRAC_BITS;

	logic [59:0]      a_s1 [5];
	logic [60:0]      c_s2 [3];
	logic [61:0]      acc_s3;
	logic [31:0]      sum_s4;
	logic [48:0]      lp_s5;
	logic [48:0]      len_full;
	logic [LEN_W-1:0] len_s6;
	logic             sat_s6;
	logic [B_W-1:0]   b_s1, b_s2, b_s3, b_s4;
	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [LEN_W-1:0] len_q [2];
	logic             sat_q [2];
	logic             hd_q;
	logic [1:0]       cnt_q;
	logic             push, pop, wr_slot;

	assign len_full = (lp_s5 + (49'd1 << (FS - 1))) >> FS;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 5; i++) begin
				a_s1[i] <= 60'(prod[2*i]) + 60'(prod[2*i+1]);
			end
			c_s2[0] <= 61'(a_s1[0]) + 61'(a_s1[1]);
			c_s2[1] <= 61'(a_s1[2]) + 61'(a_s1[3]);
			c_s2[2] <= 61'(a_s1[4]);
			acc_s3  <= 62'(c_s2[0]) + 62'(c_s2[1]) + 62'(c_s2[2]);
			sum_s4  <= 32'((acc_s3 + (62'd1 << 29)) >> 30);
			lp_s5   <= 49'(b_s4) * 49'(sum_s4);
			sat_s6  <= len_full > 49'(LEN_W'('1));
			len_s6  <= (len_full > 49'(LEN_W'('1))) ? LEN_W'('1) : LEN_W'(len_full);
			b_s1 <= b;
			b_s2 <= b_s1;
			b_s3 <= b_s2;
			b_s4 <= b_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// The pipeline runs as long as the skid buffer has a free slot.
	assign en      = cnt_q != 2'd2;
	assign push    = en & vld_s6;
	assign pop     = (cnt_q != 2'd0) & ~out_stall;
	assign wr_slot = hd_q ^ cnt_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			hd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			hd_q  <= hd_q ^ pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			len_q[wr_slot] <= len_s6;
			sat_q[wr_slot] <= sat_s6;
		end
	end

	assign out_valid  = cnt_q != 2'd0;
	assign arc_length = len_q[hd_q];
	assign saturated  = sat_q[hd_q];

endmodule

// ----- rtl/core/bezier_arc_length_quadrature_top.sv -----
// ----------------------------------------------------------------------------
// bezier_arc_length_quadrature_top: cubic Bezier arc length engine
// Gauss-Legendre quadrature of the derivative norm over [0, upper_limit].
// ----------------------------------------------------------------------------
// The block takes one query beat per clock and returns one result beat per
// query, in order. Each result is written into the two-entry output buffer,
// where it shows at the output at once when the buffer is otherwise empty.
// The input stage loads at the accepting edge. It is followed by 38 stages in
// each of the ten node lanes: eight for the derivative, one per root bit in
// the 29-stage square root, and one for the weight. Six stages of summation,
// scaling and clamping come next, and the last edge is the buffer write. The
// rate is one beat per cycle in either mode; the three-node rule runs through
// the same lanes with the unused ones weighted by zero. The input is held off
// only when the output buffer is full. The user must write the four control
// points through the write port while the block is idle; nothing enforces it.
module bezier_arc_length_quadrature_top #(
	parameter int COORD_WIDTH      = 16,
	parameter int LENGTH_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [1:0]                        wr_index,
	input  logic [bala_pkg::REG_W-1:0]        wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bala_pkg::B_W-1:0]          upper_limit,
	input  logic                              mode,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bala_pkg::LEN_W-1:0]        arc_length,
	output logic                              saturated
);
	import bala_pkg::*;

	localparam int W      = COORD_WIDTH;
	localparam int DIFF_W = W + 1;
	localparam int EXT_W  = (3 * W > REG_W) ? 3 * W : REG_W;

	logic [REG_W-1:0]         point_q [4];
	logic [EXT_W-1:0]         ext [4];
	logic signed [W-1:0]      co [4][3];
	logic signed [DIFF_W-1:0] diff_n [3][3];
	logic signed [DIFF_W-1:0] diff_q [3][3];

	logic                     en;
	logic                     vld_s0, mode_s0;
	logic [B_W-1:0]           b_s0;
	logic                     vld_dly_q [LANE_LAT];
	logic [B_W-1:0]           b_dly_q [LANE_LAT];
	logic [PROD_W-1:0]        prod [NODES];

	// Control point registers. Coordinates pack x, y, z from the low end;
	// bits above the register read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < 4; p++) begin
				point_q[p] <= '0;
			end
		end else if (wr_en) begin
			case (wr_index)
				REG_POINT_0: point_q[0] <= wr_data;
				REG_POINT_1: point_q[1] <= wr_data;
				REG_POINT_2: point_q[2] <= wr_data;
				REG_POINT_3: point_q[3] <= wr_data;
				default:     point_q[0] <= point_q[0];
			endcase
		end
	end

	always_comb begin
		for (int p = 0; p < 4; p++) begin
			ext[p] = EXT_W'(point_q[p]);
			for (int k = 0; k < 3; k++) begin
				co[p][k] = $signed(ext[p][k*W +: W]);
			end
		end
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				diff_n[k][j] = DIFF_W'(co[j+1][k]) - DIFF_W'(co[j][k]);
			end
		end
	end

	// The control point differences are static while queries flow, so they
	// are registered once and fed to every lane.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					diff_q[k][j] <= '0;
				end
			end
		end else begin
			diff_q <= diff_n;
		end
	end

	// Input stage. A limit above one is taken as one.
	assign in_stall = ~en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s0    <= upper_limit[B_W-1] ? {1'b1, {(B_W-1){1'b0}}} : upper_limit;
			mode_s0 <= mode;
		end
	end

	// Ten node lanes in parallel; each one picks its node of the chosen rule.
	for (genvar i = 0; i < NODES; i++) begin : g_lane
		bala_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
			.clk (clk),
			.en  (en),
			.b   (b_s0),
			.mode(mode_s0),
			.u   (mode_s0 ? U10[i] : U3[i]),
			.w3  (W3[i]),
			.w10 (W10[i]),
			.diff(diff_q),
			.prod(prod[i])
		);
	end

	// The beat valid and the limit travel beside the lanes to the summation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				vld_dly_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_dly_q[0] <= vld_s0;
			for (int i = 1; i < LANE_LAT; i++) begin
				vld_dly_q[i] <= vld_dly_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_dly_q[0] <= b_s0;
			for (int i = 1; i < LANE_LAT; i++) begin
				b_dly_q[i] <= b_dly_q[i-1];
			end
		end
	end

	bala_sum #(
		.COORD_WIDTH     (COORD_WIDTH),
		.LENGTH_FRAC_BITS(LENGTH_FRAC_BITS)
	) u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld       (vld_dly_q[LANE_LAT-1]),
		.b         (b_dly_q[LANE_LAT-1]),
		.prod      (prod),
		.out_stall (out_stall),
		.en        (en),
		.out_valid (out_valid),
		.arc_length(arc_length),
		.saturated (saturated)
	);

endmodule

// ----- tb/sv/tb_bezier_arc_length_quadrature_top.sv -----
// ----------------------------------------------------------------------------
// tb_bezier_arc_length_quadrature_top: arc length engine testbench
// Drives query beats from a queue, with random gaps and output stalls. A local
// fixed-point quadrature model predicts each length, and the monitor checks
// every result beat in order against it, over several control point sets.
// ----------------------------------------------------------------------------
module tb_bezier_arc_length_quadrature_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bala_pkg::*;

	localparam longint unsigned ONE_Q30 = 64'd1073741824;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic [B_W-1:0] limit;
		logic           ten_nodes;
		int             gap;
	} query_t;

	typedef struct {
		logic [LEN_W-1:0] length;
		logic             clamped;
	} length_t;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [1:0]       wr_index;
	logic [REG_W-1:0] wr_data;
	logic             in_valid;
	logic             in_stall;
	logic [B_W-1:0]   upper_limit;
	logic             mode;
	logic             out_valid;
	logic             out_stall;
	logic [LEN_W-1:0] arc_length;
	logic             saturated;

	bezier_arc_length_quadrature_top uut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.upper_limit(upper_limit), .mode(mode),
		.out_valid(out_valid), .out_stall(out_stall),
		.arc_length(arc_length), .saturated(saturated)
	);

	// Local copy of the control point registers, kept in step with the writes.
	logic [REG_W-1:0] ctrl_pts [4];

	// Node offsets from the interval center and weights, both in Q0.30.
	longint node_off3 [3] = '{0, -831716840, 831716840};
	longint unsigned node_wt3 [3] = '{954437177, 596523236, 596523236};
	longint node_off10 [10] = '{
		-159852604, 159852604, -465354761, 465354761, -729510469,
		729510469, -928854717, 928854717, -1045724172, 1045724172};
	longint unsigned node_wt10 [10] = '{
		317316720, 317316720, 289122938, 289122938, 235242191,
		235242191, 160472164, 160472164, 71587811, 71587811};

	query_t  pending_queries [$];
	length_t expected_lengths [$];

	int  mismatches;
	int  idle_cycles;
	bit  steady;
	int  hold_left;

	function automatic longint unsigned round_shr(longint unsigned v, int sh);
		return (v + (64'd1 << (sh - 1))) >> sh;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Norm of the curve derivative at t (Q0.30), with 18 fraction bits.
	function automatic longint unsigned speed_at(longint unsigned t);
		longint unsigned s, mag, m, sumsq;
		longint c0, c1, c2, d, p0, p1, p2, p3;
		s = ONE_Q30 - t;
		c0 = 3 * longint'(round_shr(s * s, 30));
		c1 = 6 * longint'(round_shr(t * s, 30));
		c2 = 3 * longint'(round_shr(t * t, 30));
		sumsq = 0;
		for (int k = 0; k < 3; k++) begin
			p0 = longint'($signed(ctrl_pts[0][k*16 +: 16]));
			p1 = longint'($signed(ctrl_pts[1][k*16 +: 16]));
			p2 = longint'($signed(ctrl_pts[2][k*16 +: 16]));
			p3 = longint'($signed(ctrl_pts[3][k*16 +: 16]));
			d = c0 * (p1 - p0) + c1 * (p2 - p1) + c2 * (p3 - p2);
			mag = (d < 0) ? longint'(-d) : longint'(d);
			m = round_shr(mag, 20);
			sumsq += m * m;
		end
		return floor_sqrt(sumsq);
	endfunction

	function automatic length_t arc_length_of(logic [B_W-1:0] limit, logic ten_nodes);
		longint unsigned b, acc, wsum, len, t;
		longint off, wt;
		length_t r;
		b = (limit > 17'd65536) ? 64'd65536 : 64'(limit);
		acc = 0;
		for (int i = 0; i < (ten_nodes ? 10 : 3); i++) begin
			off = ten_nodes ? node_off10[i] : node_off3[i];
			wt = ten_nodes ? node_wt10[i] : node_wt3[i];
			t = round_shr(b * longint'(longint'(ONE_Q30) + off), 17);
			acc += wt * speed_at(t);
		end
		wsum = round_shr(acc, 30);
		len = round_shr(b * wsum, 19);
		if (len > 64'd134217727) begin
			r.length = '1;
			r.clamped = 1'b1;
		end else begin
			r.length = len[LEN_W-1:0];
			r.clamped = 1'b0;
		end
		return r;
	endfunction

	function automatic int draw_wait();
		if (steady || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Driver: presents the head of the pending queue after its gap, and
	// predicts the length of every query beat the block accepts. The valid
	// level is computed first so it gets exactly one assignment per edge.
	always @(posedge clk) begin
		logic   next_valid;
		query_t q;
		if (arst_n) begin
			next_valid = in_valid;
			if (in_valid && !in_stall) begin
				expected_lengths.push_back(arc_length_of(upper_limit, mode));
				next_valid = 1'b0;
			end
			if (!next_valid && pending_queries.size() > 0) begin
				if (pending_queries[0].gap > 0) begin
					pending_queries[0].gap--;
				end else begin
					q = pending_queries.pop_front();
					upper_limit <= q.limit;
					mode <= q.ten_nodes;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	// Monitor: checks each accepted result beat against the oldest prediction
	// and draws a new stall run after every accepted beat.
	always @(posedge clk) begin
		length_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_lengths.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result beat: length %0d sat %0b",
							arc_length, saturated);
				end else begin
					want = expected_lengths.pop_front();
					if (want.length !== arc_length || want.clamped !== saturated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected length %0d sat %0b, got %0d sat %0b",
								want.length, want.clamped, arc_length, saturated);
					end
				end
				hold_left = draw_wait();
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: any accepted beat on either channel resets the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_point(input logic [1:0] idx, input logic [REG_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		ctrl_pts[idx] = val;
	endtask

	task automatic load_points(input logic [REG_W-1:0] a, b, c, d);
		write_point(REG_POINT_0, a);
		write_point(REG_POINT_1, b);
		write_point(REG_POINT_2, c);
		write_point(REG_POINT_3, d);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic add_query(input logic [B_W-1:0] limit, input logic ten_nodes);
		query_t q;
		q.limit = limit;
		q.ten_nodes = ten_nodes;
		q.gap = draw_wait();
		pending_queries.push_back(q);
	endtask

	// Mostly limits in the legal range, some anywhere in the 17-bit field so
	// the clamp above one and every bit of the port get exercised.
	task automatic add_random_queries(input int count);
		logic [B_W-1:0] limit;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 7))
				0: limit = $urandom_range(0, 131071);
				1: limit = 17'd65536 - $urandom_range(0, 3);
				2: limit = $urandom_range(0, 15);
				default: limit = $urandom_range(0, 65536);
			endcase
			add_query(limit, $urandom_range(0, 1));
		end
	endtask

	task automatic wait_drained();
		while (pending_queries.size() > 0 || in_valid || expected_lengths.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [REG_W-1:0] random_point();
		return {16'($urandom), 16'($urandom), 16'($urandom)};
	endfunction

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		upper_limit = '0;
		mode = 1'b0;
		out_stall = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		hold_left = 0;
		steady = 1'b0;
		for (int i = 0; i < 4; i++)
			ctrl_pts[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// A degenerate curve with all points at the origin right after reset.
		add_query(17'd65536, 1'b0);
		add_query(17'd65536, 1'b1);
		wait_drained();

		// Points alternating between the extreme coordinates give the largest
		// derivative; the directed limits cover zero, one step, one, and the
		// values above one that must be clamped.
		load_points(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
			48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF);
		foreach (node_wt3[m]) begin end
		for (int md = 0; md < 2; md++) begin
			add_query(17'd0, md[0]);
			add_query(17'd1, md[0]);
			add_query(17'd32768, md[0]);
			add_query(17'd65535, md[0]);
			add_query(17'd65536, md[0]);
			add_query(17'd65537, md[0]);
			add_query(17'h1FFFF, md[0]);
			add_query(17'h15555, md[0]);
			add_query(17'h0AAAA, md[0]);
		end
		add_random_queries(100);
		wait_drained();

		// A straight segment, then three registers at their all-ones pattern and one at zero.
		load_points(48'h0000_0000_0000, 48'h0000_0000_0100,
			48'h0000_0000_0200, 48'h0000_0000_0300);
		steady = 1'b1;
		add_random_queries(100);
		wait_drained();
		steady = 1'b0;
		load_points('1, '1, '1, 48'h0);
		add_random_queries(100);
		wait_drained();

		// Random control points, with one phase at full rate on both sides.
		for (int ph = 0; ph < 6; ph++) begin
			load_points(random_point(), random_point(), random_point(), random_point());
			steady = (ph == 2);
			add_random_queries(110);
			wait_drained();
		end

		if (mismatches == 0 && expected_lengths.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
